>>> hdl/petri_net_firing_step_unit_assert.svh
// Assertion macros for the RTL, included by pnfs_ctrl. The calling module must have clk and rst.
`ifndef PETRI_NET_FIRING_STEP_UNIT_ASSERT_SVH
`define PETRI_NET_FIRING_STEP_UNIT_ASSERT_SVH

// Checked outside reset only
`define PNFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included
`define PNFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/pnfs_pkg.sv
`default_nettype none
package pnfs_pkg;

  localparam int PLACES_MAX      = 8;
  localparam int TRANS_MAX       = 8;
  localparam int DEF_PLACES      = 8;
  localparam int DEF_TRANSITIONS = 8;
  localparam int COUNT_W         = 8;
  localparam int ARC_W           = 64;
  localparam int MARK_W          = 64;
  localparam int TIDX_W          = 3;
  localparam int REG_IDX_W       = 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INPUT_ARCS  = 1'b0,
    REG_OUTPUT_ARCS = 1'b1
  } reg_index_t;

  // controller -> datapath
  typedef struct packed {
    logic              step;
    logic              set;
    logic              clear;
    logic              fire;
    logic [TIDX_W-1:0] t;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic arm_any;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/pnfs_datapath.sv
`default_nettype none
module pnfs_datapath #(
  parameter int PLACES      = pnfs_pkg::DEF_PLACES,
  parameter int TRANSITIONS = pnfs_pkg::DEF_TRANSITIONS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [pnfs_pkg::REG_IDX_W-1:0]      wr_index,
  input  wire logic [pnfs_pkg::ARC_W-1:0]          wr_data,
  input  wire logic [pnfs_pkg::TRANS_MAX-1:0]      conditions,
  input  wire logic [2:0]                          place_index,
  input  wire logic [pnfs_pkg::COUNT_W-1:0]        mark_value,
  input  wire pnfs_pkg::cmd_t                      cmd,
  output pnfs_pkg::status_t                        status,
  output logic [pnfs_pkg::TRANS_MAX-1:0]           fired,
  output logic                                     any_armed,
  output logic [pnfs_pkg::MARK_W-1:0]              marking
);
  import pnfs_pkg::*;

  logic [ARC_W-1:0]     in_arcs;
  logic [ARC_W-1:0]     out_arcs;
  logic [COUNT_W-1:0]   counts  [PLACES];
  logic [COUNT_W-1:0]   scratch [PLACES];
  logic [TRANS_MAX-1:0] armed;
  logic [TRANS_MAX-1:0] fired_r;
  logic                 any_armed_r;

  logic [TRANS_MAX-1:0] arm_now;
  logic [5:0]           arc_base;
  logic [PLACES-1:0]    im;
  logic [PLACES-1:0]    om;
  logic                 marked;
  logic                 fire_go;
  logic [COUNT_W-1:0]   cnt_fire [PLACES];
  logic [COUNT_W-1:0]   scr_fire [PLACES];

  // arming against the live marking, with the conditions presented at start
  always_comb begin
    arm_now = '0;
    for (int t = 0; t < TRANSITIONS; t++) begin
      arm_now[t] = conditions[t];
      for (int p = 0; p < PLACES; p++) begin
        if (in_arcs[COUNT_W*t+p] && (counts[p] == '0)) arm_now[t] = 1'b0;
      end
    end
  end

  assign status.arm_any = |arm_now;

  assign arc_base = {cmd.t, 3'b000};
  assign im       = in_arcs[arc_base +: PLACES];
  assign om       = out_arcs[arc_base +: PLACES];

  always_comb begin
    marked = 1'b1;
    for (int p = 0; p < PLACES; p++) begin
      if (im[p] && (scratch[p] == '0)) marked = 1'b0;
    end
  end

  assign fire_go = armed[cmd.t] && marked;

  // one firing: saturating give, then take where non-zero
  always_comb begin
    for (int p = 0; p < PLACES; p++) begin
      cnt_fire[p] = counts[p];
      if (om[p] && (cnt_fire[p] != COUNT_MAX)) cnt_fire[p] = cnt_fire[p] + 1'b1;
      if (im[p] && (cnt_fire[p] != '0)) cnt_fire[p] = cnt_fire[p] - 1'b1;
      scr_fire[p] = scratch[p];
      if (im[p] && (scr_fire[p] != '0)) scr_fire[p] = scr_fire[p] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_arcs  <= '0;
      out_arcs <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_INPUT_ARCS:  in_arcs  <= wr_data;
        REG_OUTPUT_ARCS: out_arcs <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PLACES; p++) counts[p] <= '0;
      armed       <= '0;
      fired_r     <= '0;
      any_armed_r <= 1'b0;
    end else begin
      priority if (cmd.step) begin
        armed       <= arm_now;
        fired_r     <= '0;
        any_armed_r <= |arm_now;
        for (int p = 0; p < PLACES; p++) scratch[p] <= counts[p];
      end else if (cmd.set) begin
        armed       <= '0;
        fired_r     <= '0;
        any_armed_r <= 1'b0;
        for (int p = 0; p < PLACES; p++) begin
          if (place_index == 3'(p)) counts[p] <= mark_value;
        end
      end else if (cmd.clear) begin
        armed       <= '0;
        fired_r     <= '0;
        any_armed_r <= 1'b0;
        for (int p = 0; p < PLACES; p++) counts[p] <= '0;
      end else if (cmd.fire && fire_go) begin
        fired_r[cmd.t] <= 1'b1;
        for (int p = 0; p < PLACES; p++) begin
          counts[p]  <= cnt_fire[p];
          scratch[p] <= scr_fire[p];
        end
      end else if (cmd.fire) begin
        fired_r <= fired_r;
      end else begin
        // idle or an unused kind: the next result reports no firing
        armed       <= '0;
        fired_r     <= '0;
        any_armed_r <= 1'b0;
      end
    end
  end

  always_comb begin
    marking = '0;
    for (int p = 0; p < PLACES; p++) marking[COUNT_W*p +: COUNT_W] = counts[p];
  end

  assign fired     = fired_r;
  assign any_armed = any_armed_r;

endmodule
`default_nettype wire

>>> hdl/pnfs_ctrl.sv
`default_nettype none
module pnfs_ctrl #(
  parameter int TRANSITIONS = pnfs_pkg::DEF_TRANSITIONS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pnfs_pkg::kind_t   kind,
  input  wire pnfs_pkg::status_t status,
  output logic                   busy,
  output logic                   done,
  output pnfs_pkg::cmd_t         cmd
);
  import pnfs_pkg::*;

  `include "petri_net_firing_step_unit_assert.svh"

  localparam logic [TIDX_W-1:0] LAST = TIDX_W'(TRANSITIONS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIRE = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [TIDX_W-1:0] t, t_next;
  logic              accept;

  assign busy   = (state == S_FIRE);
  assign done   = (state == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    t_next     = t;
    unique case (state)
      S_IDLE, S_DONE: begin
        if (accept) begin
          t_next     = '0;
          state_next = (kind == KIND_STEP && status.arm_any) ? S_FIRE : S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIRE: begin
        if (t == LAST) begin
          state_next = S_DONE;
        end else begin
          t_next = t + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      t     <= '0;
    end else begin
      state <= state_next;
      t     <= t_next;
    end
  end

  assign cmd.step  = accept && (kind == KIND_STEP);
  assign cmd.set   = accept && (kind == KIND_SET);
  assign cmd.clear = accept && (kind == KIND_CLEAR);
  assign cmd.fire  = (state == S_FIRE);
  assign cmd.t     = t;

  `PNFS_ASSERT_RST(a_rst_quiet, rst |=> (!done && !busy), "result or busy straight after reset")
  `PNFS_ASSERT(a_t_walk, (state == S_FIRE && t != LAST) |=> (state == S_FIRE && t == $past(t) + 1'b1), "transition walk skipped")
  `PNFS_ASSERT(a_last_done, (state == S_FIRE && t == LAST) |=> done, "no result after last transition")
  `PNFS_ASSERT(a_unarmed_done, (accept && kind == KIND_STEP && !status.arm_any) |=> done, "unarmed step did not report at once")

endmodule
`default_nettype wire

>>> hdl/petri_net_firing_step_unit.sv
// channel   signals                                          handshake
// ------    -----------------------------------------------  -----------------------
// input     kind conditions place_index mark_value           start && !busy
// result    fired any_armed marking                          done, one cycle, no stall
// config    wr_index wr_data                                 wr_en, taken at once
//
// A step item with an armed transition walks every transition in order on the
// shared place counters, then reaches the result state, in which the next item may
// already start. Other items, and a step with nothing armed, give their result in
// the cycle after start.
// rst is synchronous and clears the counts and both arc registers.
// The receiver cannot stall: done is high for exactly one cycle per item.
`default_nettype none
module petri_net_firing_step_unit #(
  parameter int PLACES      = pnfs_pkg::DEF_PLACES,
  parameter int TRANSITIONS = pnfs_pkg::DEF_TRANSITIONS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire pnfs_pkg::kind_t                   kind,
  input  wire logic [pnfs_pkg::TRANS_MAX-1:0]    conditions,
  input  wire logic [2:0]                        place_index,
  input  wire logic [pnfs_pkg::COUNT_W-1:0]      mark_value,
  output logic                                   done,
  output logic [pnfs_pkg::TRANS_MAX-1:0]         fired,
  output logic                                   any_armed,
  output logic [pnfs_pkg::MARK_W-1:0]            marking,
  input  wire logic                              wr_en,
  input  wire logic [pnfs_pkg::REG_IDX_W-1:0]    wr_index,
  input  wire logic [pnfs_pkg::ARC_W-1:0]        wr_data
);
  import pnfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  pnfs_ctrl #(
    .TRANSITIONS(TRANSITIONS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  pnfs_datapath #(
    .PLACES     (PLACES),
    .TRANSITIONS(TRANSITIONS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .conditions (conditions),
    .place_index(place_index),
    .mark_value (mark_value),
    .cmd        (cmd),
    .status     (status),
    .fired      (fired),
    .any_armed  (any_armed),
    .marking    (marking)
  );

endmodule
`default_nettype wire

>>> dv/petri_net_firing_step_unit_tb.sv
`timescale 1ns / 1ps
module petri_net_firing_step_unit_tb;
  import pnfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  // arc settings used by the directed rows
  localparam logic [63:0] CHAIN_IN  = 64'h8040201008040201; // t takes from place t
  localparam logic [63:0] CHAIN_OUT = 64'h0180402010080402; // t gives to place t+1, and t 7 to place 0
  localparam logic [63:0] FORK_IN   = 64'h0101010101010101; // every t competes for place 0
  localparam logic [63:0] ALL_ARCS  = '1;

  typedef struct packed {
    logic [TRANS_MAX-1:0] fired;
    logic                 any_armed;
    logic [MARK_W-1:0]    marking;
  } firing_result_t;

  typedef enum logic {ROW_ITEM, ROW_ARCS} row_op_t;

  typedef struct packed {
    row_op_t              op;
    kind_t                kind;
    logic [TRANS_MAX-1:0] cond;
    logic [2:0]           pidx;
    logic [COUNT_W-1:0]   val;
    logic [ARC_W-1:0]     arcs_in;
    logic [ARC_W-1:0]     arcs_out;
    logic                 typed;
    firing_result_t       result;
  } stim_row_t;

  localparam stim_row_t DIRECTED [24] = '{
    // empty input masks: armed by condition alone
    '{ROW_ITEM, KIND_STEP,  8'hFF, 3'd0, 8'h00, '0, '0, 1'b1, '{8'hFF, 1'b1, 64'h0}},
    '{ROW_ITEM, KIND_STEP,  8'h00, 3'd0, 8'h00, '0, '0, 1'b1, '{8'h00, 1'b0, 64'h0}},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd0, 8'hFF, '0, '0, 1'b1, '{8'h00, 1'b0, 64'hFF}},
    '{ROW_ITEM, KIND_SET,   8'hFF, 3'd7, 8'h80, '0, '0, 1'b1,
      '{8'h00, 1'b0, 64'h8000_0000_0000_00FF}},
    '{ROW_ITEM, KIND_NONE,  8'hFF, 3'd3, 8'h55, '0, '0, 1'b1,
      '{8'h00, 1'b0, 64'h8000_0000_0000_00FF}},
    '{ROW_ITEM, KIND_CLEAR, 8'hFF, 3'd7, 8'hFF, '0, '0, 1'b1, '{8'h00, 1'b0, 64'h0}},
    '{ROW_ARCS, KIND_NONE,  8'h00, 3'd0, 8'h00, CHAIN_IN, CHAIN_OUT, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd0, 8'h03, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_STEP,  8'h01, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_STEP,  8'hFF, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd3, 8'hFF, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd2, 8'hFF, '0, '0, 1'b0, '0},
    // output place already full
    '{ROW_ITEM, KIND_STEP,  8'h04, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ARCS, KIND_NONE,  8'h00, 3'd0, 8'h00, FORK_IN, CHAIN_IN, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd0, 8'h02, '0, '0, 1'b0, '0},
    // all armed, only two tokens on the shared place
    '{ROW_ITEM, KIND_STEP,  8'hFF, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd0, 8'hFF, '0, '0, 1'b0, '0},
    // self loop on a full place
    '{ROW_ITEM, KIND_STEP,  8'h01, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_STEP,  8'hFF, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ARCS, KIND_NONE,  8'h00, 3'd0, 8'h00, ALL_ARCS, ALL_ARCS, 1'b0, '0},
    '{ROW_ITEM, KIND_SET,   8'h00, 3'd5, 8'h01, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_STEP,  8'hAA, 3'd0, 8'h00, '0, '0, 1'b0, '0},
    '{ROW_ITEM, KIND_CLEAR, 8'h00, 3'd0, 8'h00, '0, '0, 1'b1, '{8'h00, 1'b0, 64'h0}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  kind_t                 kind = KIND_STEP;
  logic [TRANS_MAX-1:0]  conditions = '0;
  logic [2:0]            place_index = '0;
  logic [COUNT_W-1:0]    mark_value = '0;
  logic                  done;
  logic [TRANS_MAX-1:0]  fired;
  logic                  any_armed;
  logic [MARK_W-1:0]     marking;
  logic                  wr_en = 1'b0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [ARC_W-1:0]      wr_data = '0;

  // hand-typed expectation travelling alongside start
  logic                  fixed_valid = 1'b0;
  firing_result_t        fixed_result = '0;

  // predictor state
  logic [ARC_W-1:0]      in_arcs;
  logic [ARC_W-1:0]      out_arcs;
  logic [MARK_W-1:0]     pred_marking;

  firing_result_t        expected_firings [$];
  int                    items_sent = 0;
  int                    results_seen = 0;
  int                    firing_results = 0;
  int                    arc_settings = 0;
  int                    errors = 0;
  int                    idle_pct = 0;
  int                    quiet_cycles = 0;

  petri_net_firing_step_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .conditions  (conditions),
    .place_index (place_index),
    .mark_value  (mark_value),
    .done        (done),
    .fired       (fired),
    .any_armed   (any_armed),
    .marking     (marking),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always #10 clk = ~clk;

  function automatic logic all_marked(logic [7:0] mask, logic [MARK_W-1:0] m);
    for (int p = 0; p < DEF_PLACES; p++) begin
      if (mask[p] && m[8*p +: 8] == '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic firing_result_t fire_step(kind_t k, logic [7:0] cond, logic [2:0] pidx,
                                               logic [7:0] val);
    firing_result_t    r;
    logic [7:0]        armed;
    logic [7:0]        im;
    logic [7:0]        om;
    logic [MARK_W-1:0] scratch;
    r = '0;
    armed = '0;
    case (k)
      KIND_STEP: begin
        for (int t = 0; t < DEF_TRANSITIONS; t++) begin
          if (cond[t] && all_marked(in_arcs[8*t +: 8], pred_marking)) armed[t] = 1'b1;
        end
        if (armed != '0) begin
          scratch = pred_marking;
          for (int t = 0; t < DEF_TRANSITIONS; t++) begin
            im = in_arcs[8*t +: 8];
            om = out_arcs[8*t +: 8];
            if (armed[t] && all_marked(im, scratch)) begin
              for (int p = 0; p < DEF_PLACES; p++) begin
                if (om[p] && pred_marking[8*p +: 8] != COUNT_MAX)
                  pred_marking[8*p +: 8] = pred_marking[8*p +: 8] + 8'd1;
              end
              for (int p = 0; p < DEF_PLACES; p++) begin
                if (im[p] && pred_marking[8*p +: 8] != '0)
                  pred_marking[8*p +: 8] = pred_marking[8*p +: 8] - 8'd1;
                if (im[p] && scratch[8*p +: 8] != '0)
                  scratch[8*p +: 8] = scratch[8*p +: 8] - 8'd1;
              end
              r.fired[t] = 1'b1;
            end
          end
        end
      end
      KIND_SET: if (int'(pidx) < DEF_PLACES) pred_marking[8*pidx +: 8] = val;
      KIND_CLEAR: pred_marking = '0;
      default: ;
    endcase
    r.any_armed = (armed != '0);
    r.marking = pred_marking;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // checker and predictor, all sampled at the rising edge
  always @(posedge clk) begin : monitor
    firing_result_t want;
    logic           active;
    active = 1'b0;
    if (rst) begin
      in_arcs = '0;
      out_arcs = '0;
      pred_marking = '0;
    end else begin
      if (wr_en) begin
        active = 1'b1;
        case (reg_index_t'(wr_index))
          REG_INPUT_ARCS:  in_arcs = wr_data;
          REG_OUTPUT_ARCS: out_arcs = wr_data;
          default: ;
        endcase
      end
      if (done) begin
        active = 1'b1;
        results_seen <= results_seen + 1;
        if (fired != '0) firing_results++;
        if (expected_firings.size() == 0) begin
          $display("%0t: result with nothing expected, got fired %0h armed %0b marking %0h",
                   $time, fired, any_armed, marking);
          errors++;
        end else begin
          want = expected_firings.pop_front();
          check_field("fired", 64'(want.fired), 64'(fired));
          check_field("any_armed", 64'(want.any_armed), 64'(any_armed));
          check_field("marking", want.marking, marking);
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        want = fire_step(kind, conditions, place_index, mark_value);
        if (fixed_valid) want = fixed_result;
        expected_firings.push_back(want);
      end
    end
    quiet_cycles = active ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL petri_net_firing_step_unit");
      $finish;
    end
  end

  task automatic send_item(input kind_t k, input logic [7:0] c, input logic [2:0] p,
                           input logic [7:0] v, input logic has_fixed,
                           input firing_result_t fixed);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    conditions   <= c;
    place_index  <= p;
    mark_value   <= v;
    fixed_valid  <= has_fixed;
    fixed_result <= fixed;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  v;
    pick = $urandom_range(99);
    // mostly small counts so that transitions keep arming
    v = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    if (pick < 60)
      send_item(KIND_STEP, 8'($urandom), 3'($urandom), v, 1'b0, '0);
    else if (pick < 88)
      send_item(KIND_SET, 8'($urandom), 3'($urandom), v, 1'b0, '0);
    else if (pick < 94)
      send_item(KIND_CLEAR, 8'($urandom), 3'($urandom), v, 1'b0, '0);
    else
      send_item(KIND_NONE, 8'($urandom), 3'($urandom), v, 1'b0, '0);
  endtask

  // results come one per item, so the block is idle once the count matches
  task automatic wait_for_results();
    start <= 1'b0;
    while (results_seen + int'(done) != items_sent) @(posedge clk);
  endtask

  task automatic load_arcs(input logic [ARC_W-1:0] ins, input logic [ARC_W-1:0] outs);
    wr_en    <= 1'b1;
    wr_index <= REG_INPUT_ARCS;
    wr_data  <= ins;
    @(posedge clk);
    wr_index <= REG_OUTPUT_ARCS;
    wr_data  <= outs;
    @(posedge clk);
    wr_en <= 1'b0;
    arc_settings++;
  endtask

  function automatic logic [ARC_W-1:0] sparse_arcs(int unsigned max_bits);
    logic [ARC_W-1:0] m;
    m = '0;
    for (int t = 0; t < DEF_TRANSITIONS; t++) begin
      repeat ($urandom_range(max_bits)) m[8*t + $urandom_range(7)] = 1'b1;
    end
    return m;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].op == ROW_ARCS) begin
        wait_for_results();
        load_arcs(DIRECTED[i].arcs_in, DIRECTED[i].arcs_out);
      end else begin
        send_item(DIRECTED[i].kind, DIRECTED[i].cond, DIRECTED[i].pidx, DIRECTED[i].val,
                  DIRECTED[i].typed, DIRECTED[i].result);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 75 : (phase == 3) ? 34 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        wait_for_results();
        if (blk == 2)
          load_arcs({$urandom, $urandom}, {$urandom, $urandom});
        else
          load_arcs(sparse_arcs(2), sparse_arcs(3));
        repeat (70) send_random_item();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_firings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_firings.size());
      errors++;
    end

    $display("Sent %0d items over %0d arc settings; %0d results, %0d with firings.",
             items_sent, arc_settings, results_seen, firing_results);
    $display("Sender idle rates 0, 75 and 34 percent; %0d mismatches.", errors);
    if (errors == 0)
      $display("PASS petri_net_firing_step_unit");
    else
      $display("FAIL petri_net_firing_step_unit");
    $finish;
  end

endmodule
